// ===== sv/ofc_pkg.sv =====
package ofc_pkg;

  localparam int FLOW_WIDTH = 24;
  localparam int CW         = FLOW_WIDTH + 11;
  localparam int ZW         = 20;
  localparam int HW         = 19;
  localparam int STEPS      = 16;

  localparam logic [HW-1:0] HUE_FULL = 19'd393216;
  localparam logic [HW-1:0] HUE_HALF = 19'd196608;

  localparam logic [31:0] INV_GAIN  = 32'd2608131496;
  localparam logic [31:0] N_LOW     = 32'd268435;
  localparam logic [31:0] N_HIGH    = 32'd26843546;
  localparam logic [31:0] S_OFFSET  = 32'd4294967;
  localparam logic [28:0] LN_DEN    = 29'd405447814;
  localparam logic [16:0] V_ONE     = 17'd65536;
  localparam logic [31:0] LN_RECIP  = 32'((64'd1 << 60) / 64'd405447814);
  localparam logic [31:0] RECIP3    = 32'hAAAAAAAB;
  localparam logic [31:0] RECIP5    = 32'hCCCCCCCD;

  localparam logic [15:0] STEP_ANGLE [0:STEPS-1] = '{
    16'd49152, 16'd29016, 16'd15331, 16'd7782, 16'd3906, 16'd1955, 16'd978, 16'd489,
    16'd244, 16'd122, 16'd61, 16'd31, 16'd15, 16'd8, 16'd4, 16'd2
  };

  // hue sextants: first letter full channel, second the ramping one
  localparam logic [2:0] SXT_R_G = 3'd0;
  localparam logic [2:0] SXT_G_R = 3'd1;
  localparam logic [2:0] SXT_G_B = 3'd2;
  localparam logic [2:0] SXT_B_G = 3'd3;
  localparam logic [2:0] SXT_B_R = 3'd4;
  localparam logic [2:0] SXT_R_B = 3'd5;

  typedef struct packed {
    logic signed [FLOW_WIDTH-1:0] flow_x;
    logic signed [FLOW_WIDTH-1:0] flow_y;
    logic                         last_pixel;
  } ofc_in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } ofc_out_t;

  typedef struct packed {
    logic [31:0]   mag;
    logic [HW-1:0] hue;
    logic          last;
  } ofc_polar_t;

  typedef struct packed {
    logic [HW-1:0] hue;
    logic          last;
    logic          lo;
    logic          hi;
  } ofc_tag_t;

endpackage

// ===== sv/optical_flow_to_color_pixel.sv =====
// Each accepted request passes through ofc_cordic, then ofc_color, to its out_valid strobe.
// Throughput: one request per cycle; busy never rises.
// Depth is set by the 16 CORDIC iteration stages and the log/divide chain.
// Reset (rst_n low, synchronous) clears all valid bits; in-flight requests
// are dropped. The receiver cannot stall, so results leave as they finish.
module optical_flow_to_color_pixel import ofc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ofc_in_t  in_item,
  output logic     out_valid,
  output ofc_out_t out_item
);

  localparam int LAT = STEPS + 2 + 13;

  logic       in_valid;
  logic       pol_valid;
  ofc_polar_t polar;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  ofc_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (pol_valid),
    .out_polar (polar)
  );

  ofc_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pol_valid),
    .in_polar  (polar),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, LAT))
    else $error("result without matching request");

endmodule

// ===== sv/ofc_cordic.sv =====
module ofc_cordic import ofc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  ofc_in_t    in_item,
  output logic       out_valid,
  output ofc_polar_t out_polar
);

  logic signed [CW-1:0] a_r [0:STEPS];
  logic signed [CW-1:0] b_r [0:STEPS];
  logic signed [ZW-1:0] z_r [0:STEPS];
  logic                 v_r [0:STEPS];
  logic                 last_r [0:STEPS];

  logic signed [CW-1:0] nx, ny, a0_nxt, b0_nxt;
  logic signed [ZW-1:0] z0_nxt;

  always_comb begin
    nx = -$signed({{3{in_item.flow_x[FLOW_WIDTH-1]}}, in_item.flow_x, 8'b0});
    ny = -$signed({{3{in_item.flow_y[FLOW_WIDTH-1]}}, in_item.flow_y, 8'b0});
    if (nx < 0) begin
      a0_nxt = -nx;
      b0_nxt = -ny;
      z0_nxt = $signed({1'b0, HUE_HALF});
    end else begin
      a0_nxt = nx;
      b0_nxt = ny;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_r[0]    <= a0_nxt;
    b_r[0]    <= b0_nxt;
    z_r[0]    <= z0_nxt;
    last_r[0] <= in_item.last_pixel;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] da, db, a_nxt, b_nxt;
    logic signed [ZW-1:0] ang, z_nxt;

    always_comb begin
      da  = b_r[i] >>> i;
      db  = a_r[i] >>> i;
      ang = $signed({4'b0, STEP_ANGLE[i]});
      if (b_r[i] > 0) begin
        a_nxt = a_r[i] + da;
        b_nxt = b_r[i] - db;
        z_nxt = z_r[i] + ang;
      end else begin
        a_nxt = a_r[i] - da;
        b_nxt = b_r[i] + db;
        z_nxt = z_r[i] - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      a_r[i+1]    <= a_nxt;
      b_r[i+1]    <= b_nxt;
      z_r[i+1]    <= z_nxt;
      last_r[i+1] <= last_r[i];
    end
  end

  logic signed [63:0]   a64;
  logic signed [ZW-1:0] zw;
  logic [31:0]          mag_nxt, mag_r;
  logic [HW-1:0]        hue_nxt, hue_r;
  logic                 last_out_r, v_out_r;

  always_comb begin
    a64 = 64'(a_r[STEPS]);
    if (a64 < 0) begin
      mag_nxt = '0;
    end else if (a64 > 64'sh0FFFFFFFF) begin
      mag_nxt = 32'hFFFFFFFF;
    end else begin
      mag_nxt = a64[31:0];
    end
    if (z_r[STEPS] < 0) begin
      zw = z_r[STEPS] + $signed({1'b0, HUE_FULL});
    end else begin
      zw = z_r[STEPS];
    end
    hue_nxt = zw[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else begin
      v_out_r <= v_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    hue_r      <= hue_nxt;
    last_out_r <= last_r[STEPS];
  end

  assign out_valid = v_out_r;
  assign out_polar = '{mag: mag_r, hue: hue_r, last: last_out_r};

  a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_polar.hue < HUE_FULL)
    else $error("hue outside one turn");

endmodule

// ===== sv/ofc_color.sv =====
module ofc_color import ofc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  ofc_polar_t in_polar,
  output logic       out_valid,
  output ofc_out_t   out_item
);

  logic     v_r   [0:11];
  ofc_tag_t tag_r [0:11];

  logic [31:0] n_r;
  logic [28:0] s_r, s2_r, s3_r, s4_r;
  logic [25:0] p2_r;
  logic [22:0] p3_r;
  logic [19:0] p4_r;
  logic [16:0] p5_r;
  logic [21:0] d3_r;
  logic [14:0] d5_r;
  logic signed [30:0] acc3_r, acc4_r, acc5_r, acc6_r;
  logic [29:0] l_r, l8_r, l9_r;
  logic [17:0] q0_r, q0b_r;
  logic [46:0] qd_r;
  logic [16:0] vq_r;
  logic [7:0]  full_r;
  logic [32:0] vk_r;
  ofc_out_t    out_r;
  logic        v_out_r;

  logic [63:0] prod_m;
  logic [35:0] sw;
  logic        lo_nxt, hi_nxt;
  logic [57:0] m2;
  logic [54:0] m3, m3d;
  logic [51:0] m4;
  logic [48:0] m5, m5d;
  logic signed [30:0] acc3_nxt, acc5_nxt, lsum;
  logic [29:0] l_nxt;
  logic [61:0] mq;
  logic [46:0] qd, rem;
  logic [17:0] qc;
  logic [16:0] vq_nxt;
  logic [16:0] f;
  logic [17:0] kw;
  logic [24:0] fw;
  logic [32:0] vk_nxt;
  logic [40:0] mw;
  logic [7:0]  mid;
  logic [2:0]  sxt;
  ofc_out_t    out_nxt;

  always_comb begin
    prod_m   = 64'(in_polar.mag) * 64'(INV_GAIN);
    lo_nxt   = n_r <= N_LOW;
    hi_nxt   = n_r >= N_HIGH;
    sw       = {n_r, 4'b0} - 36'(S_OFFSET);
    m2       = 58'(s_r) * 58'(s_r);
    m3       = 55'(p2_r) * 55'(s2_r);
    acc3_nxt = $signed({2'b0, s2_r}) - $signed({6'b0, p2_r[25:1]});
    m4       = 52'(p3_r) * 52'(s3_r);
    m3d      = 55'(p3_r) * 55'(RECIP3);
    m5       = 49'(p4_r) * 49'(s4_r);
    acc5_nxt = acc4_r + $signed({9'b0, d3_r}) - $signed({13'b0, p4_r[19:2]});
    m5d      = 49'(p5_r) * 49'(RECIP5);
    lsum     = acc6_r + $signed({16'b0, d5_r});
    l_nxt    = (lsum > 0) ? lsum[29:0] : '0;
    mq       = 62'(l_r) * 62'(LN_RECIP);
    qd       = 47'(q0_r) * 47'(LN_DEN);
    rem      = {1'b0, l9_r, 16'b0} - qd_r;
    qc       = (rem >= 47'(LN_DEN)) ? q0b_r + 18'd1 : q0b_r;
    if (tag_r[9].lo) begin
      vq_nxt = '0;
    end else if (tag_r[9].hi || qc > 18'(V_ONE)) begin
      vq_nxt = V_ONE;
    end else begin
      vq_nxt = qc[16:0];
    end
    f      = tag_r[10].hue[16:0];
    kw     = f[16] ? 18'd131072 - 18'(f) : 18'(f);
    fw     = {vq_r, 8'b0} - 25'(vq_r);
    vk_nxt = 33'(vq_r) * 33'(kw[16:0]);
    mw     = {vk_r, 8'b0} - 41'(vk_r);
    mid    = mw[39:32];
    sxt    = tag_r[11].hue[HW-1:16];
  end

  always_comb begin
    out_nxt = '{blue: 8'd0, green: 8'd0, red: 8'd0, frame_end: tag_r[11].last};
    case (sxt)
      SXT_R_G: begin
        out_nxt.red   = full_r;
        out_nxt.green = mid;
      end
      SXT_G_R: begin
        out_nxt.red   = mid;
        out_nxt.green = full_r;
      end
      SXT_G_B: begin
        out_nxt.green = full_r;
        out_nxt.blue  = mid;
      end
      SXT_B_G: begin
        out_nxt.green = mid;
        out_nxt.blue  = full_r;
      end
      SXT_B_R: begin
        out_nxt.red   = mid;
        out_nxt.blue  = full_r;
      end
      default: begin
        out_nxt.red   = full_r;
        out_nxt.blue  = mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 12; j++) begin
        v_r[j] <= 1'b0;
      end
      v_out_r <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int j = 1; j < 12; j++) begin
        v_r[j] <= v_r[j-1];
      end
      v_out_r <= v_r[11];
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= '{hue: in_polar.hue, last: in_polar.last, lo: 1'b0, hi: 1'b0};
    tag_r[1] <= '{hue: tag_r[0].hue, last: tag_r[0].last, lo: lo_nxt, hi: hi_nxt};
    for (int j = 2; j < 12; j++) begin
      tag_r[j] <= tag_r[j-1];
    end
    n_r    <= prod_m[63:32];
    s_r    <= sw[28:0];
    p2_r   <= m2[57:32];
    s2_r   <= s_r;
    p3_r   <= m3[54:32];
    s3_r   <= s2_r;
    acc3_r <= acc3_nxt;
    p4_r   <= m4[51:32];
    d3_r   <= m3d[54:33];
    s4_r   <= s3_r;
    acc4_r <= acc3_r;
    p5_r   <= m5[48:32];
    acc5_r <= acc5_nxt;
    d5_r   <= m5d[48:34];
    acc6_r <= acc5_r;
    l_r    <= l_nxt;
    q0_r   <= mq[61:44];
    l8_r   <= l_r;
    qd_r   <= qd;
    q0b_r  <= q0_r;
    l9_r   <= l8_r;
    vq_r   <= vq_nxt;
    full_r <= fw[23:16];
    vk_r   <= vk_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = v_out_r;
  assign out_item  = out_r;

  a_vq_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[10] |-> vq_r <= V_ONE)
    else $error("value above one");

  a_class_excl: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> !(tag_r[1].lo && tag_r[1].hi))
    else $error("magnitude both below and above range");

  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[10] && vq_r == '0) |=> (full_r == '0 && vk_r == '0))
    else $error("zero value gives nonzero channel");

endmodule
